/* src/msb_pkg.sv */
// Shared types and constants for the multiset bag table.
`default_nettype none

package msb_pkg;

  localparam int KIND_W      = 2;
  localparam int VALUE_W     = 32;
  localparam int CNT_OUT_W   = 5;
  localparam int CNT_MAX_W   = 9;   // count width at the largest capacity
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QFILL_W     = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [KIND_W-1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_COUNT  = 2'd2,
    OP_CLEAR  = 2'd3
  } msb_kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EXEC,
    ST_MOVE
  } msb_state_t;

  // request as it appears on the input port
  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [VALUE_W-1:0] value;
  } msb_req_t;

  // request after decode, as held in the queue
  typedef struct packed {
    msb_kind_t          kind;
    logic [VALUE_W-1:0] value;
  } msb_op_t;

  // queue head seen by the back end
  typedef struct packed {
    logic    valid;
    msb_op_t op;
  } msb_q_t;

  typedef struct packed {
    logic                 success;
    logic [CNT_OUT_W-1:0] match_count;
    logic [CNT_OUT_W-1:0] size_after;
  } msb_res_t;

  function automatic logic [CNT_OUT_W-1:0] cnt_out(input logic [CNT_MAX_W-1:0] n);
    return n[CNT_OUT_W-1:0];
  endfunction

endpackage

`default_nettype wire

/* src/msb_front.sv */
// Front end: takes requests, decodes the kind and queues them for the back end.
`default_nettype none

module msb_front
  import msb_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  input  wire msb_req_t in_req,
  output logic          busy,
  output msb_q_t        q,
  input  wire logic     pop
);

  msb_op_t             slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QFILL_W-1:0]  fill_r, fill_nxt;
  logic                push;
  logic                do_pop;
  msb_op_t             dec_op;

  assign busy   = (fill_r == QFILL_W'(QUEUE_DEPTH));
  assign push   = start && !busy;
  assign do_pop = pop && (fill_r != '0);

  always_comb begin
    dec_op.kind  = msb_kind_t'(in_req.kind);
    dec_op.value = in_req.value;
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (push) begin
      wr_ptr_nxt = wr_ptr_r + QPTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = rd_ptr_r + QPTR_W'(1);
    end
    if (push && !do_pop) begin
      fill_nxt = fill_r + QFILL_W'(1);
    end else if (do_pop && !push) begin
      fill_nxt = fill_r - QFILL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= dec_op;
    end
  end

  always_comb begin
    q.valid = (fill_r != '0);
    q.op    = slot_r[rd_ptr_r];
  end

endmodule

`default_nettype wire

/* src/msb_back.sv */
// Back end: entry memory, match scan and the add/remove/count/clear sequencer.
`default_nettype none

module msb_back
  import msb_pkg::*;
#(
  parameter int CAPACITY    = 16,
  parameter int ENTRY_WIDTH = 32
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire msb_q_t q,
  output logic        pop,
  output logic        out_strobe,
  output msb_res_t    out_res
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  logic [ENTRY_WIDTH-1:0] mem [CAPACITY];

  msb_state_t             state_r, state_nxt;
  logic [CW-1:0]          count_r, count_nxt;
  logic                   cmp_v_r, cmp_v_nxt;
  logic                   out_strobe_r, out_strobe_nxt;

  msb_kind_t              kind_r, kind_nxt;
  logic [ENTRY_WIDTH-1:0] key_r, key_nxt;
  logic [CW-1:0]          idx_r, idx_nxt;
  logic [IW-1:0]          cmp_idx_r, cmp_idx_nxt;
  logic [CW-1:0]          match_r, match_nxt;
  logic                   found_r, found_nxt;
  logic [IW-1:0]          found_idx_r, found_idx_nxt;
  logic [ENTRY_WIDTH-1:0] rdata_r;
  msb_res_t               out_res_r, out_res_nxt;

  logic [IW-1:0]          rd_addr;
  logic                   we;
  logic [IW-1:0]          wa;
  logic [ENTRY_WIDTH-1:0] wd;
  logic [63:0]            val_ext;
  logic [CW-1:0]          last_w;
  logic                   emit;
  logic                   ok;

  assign val_ext = 64'(q.op.value);
  assign last_w  = count_r - CW'(1);

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    cmp_v_nxt      = 1'b0;
    out_strobe_nxt = 1'b0;
    kind_nxt       = kind_r;
    key_nxt        = key_r;
    idx_nxt        = idx_r;
    cmp_idx_nxt    = cmp_idx_r;
    match_nxt      = match_r;
    found_nxt      = found_r;
    found_idx_nxt  = found_idx_r;
    out_res_nxt    = out_res_r;
    rd_addr        = idx_r[IW-1:0];
    we             = 1'b0;
    wa             = count_r[IW-1:0];
    wd             = key_r;
    pop            = 1'b0;
    emit           = 1'b0;
    ok             = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (q.valid) begin
          pop       = 1'b1;
          kind_nxt  = q.op.kind;
          key_nxt   = val_ext[ENTRY_WIDTH-1:0];
          idx_nxt   = '0;
          match_nxt = '0;
          found_nxt = 1'b0;
          state_nxt = ST_SCAN;
        end
      end

      ST_SCAN: begin
        // read one entry per cycle, compare it the cycle after
        if (idx_r < count_r) begin
          idx_nxt     = idx_r + CW'(1);
          cmp_v_nxt   = 1'b1;
          cmp_idx_nxt = idx_r[IW-1:0];
        end
        if (cmp_v_r && (rdata_r == key_r)) begin
          match_nxt = match_r + CW'(1);
          if (!found_r) begin
            found_nxt     = 1'b1;
            found_idx_nxt = cmp_idx_r;
          end
        end
        if ((idx_r >= count_r) && !cmp_v_r) begin
          state_nxt = ST_EXEC;
        end
      end

      ST_EXEC: begin
        rd_addr = last_w[IW-1:0];
        case (kind_r)
          OP_ADD: begin
            emit = 1'b1;
            if (count_r < CW'(CAPACITY)) begin
              we        = 1'b1;
              count_nxt = count_r + CW'(1);
              ok        = 1'b1;
            end
          end
          OP_REMOVE: begin
            if (found_r) begin
              state_nxt = ST_MOVE;
            end else begin
              emit = 1'b1;
            end
          end
          OP_COUNT: begin
            emit = 1'b1;
            ok   = (match_r != '0);
          end
          OP_CLEAR: begin
            emit      = 1'b1;
            count_nxt = '0;
            ok        = 1'b1;
          end
          default: begin
            emit = 1'b1;
          end
        endcase
      end

      ST_MOVE: begin
        // last entry fills the hole left by the removed one
        we        = 1'b1;
        wa        = found_idx_r;
        wd        = rdata_r;
        count_nxt = last_w;
        ok        = 1'b1;
        emit      = 1'b1;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (emit) begin
      state_nxt               = ST_IDLE;
      out_strobe_nxt          = 1'b1;
      out_res_nxt.success     = ok;
      out_res_nxt.match_count = cnt_out(CNT_MAX_W'(match_r));
      out_res_nxt.size_after  = cnt_out(CNT_MAX_W'(count_nxt));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      count_r      <= '0;
      cmp_v_r      <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      cmp_v_r      <= cmp_v_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r      <= kind_nxt;
    key_r       <= key_nxt;
    idx_r       <= idx_nxt;
    cmp_idx_r   <= cmp_idx_nxt;
    match_r     <= match_nxt;
    found_r     <= found_nxt;
    found_idx_r <= found_idx_nxt;
    out_res_r   <= out_res_nxt;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rdata_r <= mem[rd_addr];
  end

  assign out_strobe = out_strobe_r;
  assign out_res    = out_res_r;

endmodule

`default_nettype wire

/* src/multiset_bag_table.sv */
// Top level of the multiset bag table: request queue plus scan/execute engine.
//
// Usage:
//   A request (in_req.kind, in_req.value) is taken at a rising edge where
//   start is high and busy is low. Kinds: add, remove first match, count
//   matches, clear. Only the low ENTRY_WIDTH bits of value take part.
//   Every request yields exactly one result on out_res, shown for a single
//   cycle with out_strobe high; the receiver has no way to hold it off, so
//   it must take it in that cycle.
//   Queue: the front holds up to two requests, so busy rises only once
//   both slots are taken.
//   Scan: the back end scans all held entries through a single memory
//   read port, one entry per cycle, to get the match count, and takes
//   no new request from the queue until the current one has finished;
//   a remove that hits also reads and moves the last entry.
//   Reset (rst_n low, synchronous) empties the bag and the queue; entry
//   memory keeps stale contents, which are never read before a new write.
`default_nettype none

module multiset_bag_table
  import msb_pkg::*;
#(
  parameter int CAPACITY    = 16,
  parameter int ENTRY_WIDTH = 32
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  input  wire msb_req_t in_req,
  output logic          busy,
  output logic          out_strobe,
  output msb_res_t      out_res
);

  msb_q_t q;
  logic   pop;

  // accept and decode, two-deep request queue
  msb_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .in_req (in_req),
    .busy   (busy),
    .q      (q),
    .pop    (pop)
  );

  // entry memory, match scan, and the update of the bag
  msb_back #(
    .CAPACITY    (CAPACITY),
    .ENTRY_WIDTH (ENTRY_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q          (q),
    .pop        (pop),
    .out_strobe (out_strobe),
    .out_res    (out_res)
  );

endmodule

`default_nettype wire

/* src/msb_check.sv */
// Port-level checker for the multiset bag table, bound to the top level.
`default_nettype none

module msb_check
  import msb_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input wire logic     clk,
  input wire logic     rst_n,
  input wire logic     start,
  input wire msb_req_t in_req,
  input wire logic     busy,
  input wire logic     out_strobe,
  input wire msb_res_t out_res
);

  // each request passes through the scan and execute states, so results never come back to back
  a_no_double_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("result strobe on two consecutive cycles");

  // reported size and match count never exceed the capacity (checked only for CAPACITY up to 31)
  a_size_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (CAPACITY > 31) ||
                   ((out_res.size_after <= CNT_OUT_W'(CAPACITY)) &&
                    (out_res.match_count <= CNT_OUT_W'(CAPACITY))))
    else $error("size or match count beyond capacity");

  // no result right after reset is released
  a_quiet_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(rst_n) |-> !out_strobe)
    else $error("result strobe straight out of reset");

  // queue only fills up right after a request was taken
  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start && !busy))
    else $error("busy rose without a request");

  // a taken request carries known fields
  a_req_known: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> !$isunknown(in_req))
    else $error("request taken with unknown fields");

endmodule

bind multiset_bag_table msb_check #(.CAPACITY(CAPACITY)) u_msb_check (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .in_req     (in_req),
  .busy       (busy),
  .out_strobe (out_strobe),
  .out_res    (out_res)
);

`default_nettype wire
